FILE: hdl/best_fit_buffer_pool_core_assert.svh
// Assertion macros used by the buffer pool RTL.
// Every macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef BEST_FIT_BUFFER_POOL_CORE_ASSERT_SVH
`define BEST_FIT_BUFFER_POOL_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BFBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bfbp_pkg.sv
// Shared widths, codes and types of the best-fit buffer pool.
// No dependencies; every other file of the block but the assertion header uses it.
package bfbp_pkg;

  localparam int SIZE_W         = 25;
  localparam int CAP_W          = 26;
  localparam int SLOT_W         = 4;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 2;
  localparam int POOL_DEPTH_DEF = 16;

  localparam logic [SIZE_W-1:0]     BASE_SIZE_RST  = 25'd65536;
  localparam logic [APB_ADDR_W-1:0] ADDR_BASE_SIZE = 2'd0;

  // Operation codes of the input item.
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_REUSED   = 3'd0,
    ST_CREATED  = 3'd1,
    ST_ZERO     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOT_BUSY = 3'd4,
    ST_RELEASED = 3'd5
  } status_e;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              dir;
    logic              found;
    logic [SIZE_W-1:0] size;
    logic [CAP_W-1:0]  best_cap;
  } tok_t;

  // Update broadcast from the controller to all cells.
  typedef struct packed {
    logic             we_cap;
    logic             set_busy;
    logic             clr_busy;
    logic             dir;
    logic [CAP_W-1:0] cap;
  } wcmd_t;

endpackage

FILE: hdl/bfbp_in_if.sv
// Request channel of the buffer pool: valid/ready plus the request fields.
// Depends on bfbp_pkg for the field widths.
interface bfbp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic                        direction;
  logic [bfbp_pkg::SIZE_W-1:0] request_size;
  logic [bfbp_pkg::SLOT_W-1:0] slot;

  modport source (output valid, op, direction, request_size, slot, input ready);
  modport sink   (input valid, op, direction, request_size, slot, output ready);
endinterface

FILE: hdl/bfbp_out_if.sv
// Result channel of the buffer pool: valid/ready plus the result fields.
// Depends on bfbp_pkg for the field widths and the status type.
interface bfbp_out_if;
  logic                        valid;
  logic                        ready;
  bfbp_pkg::status_e           status;
  logic [bfbp_pkg::SLOT_W-1:0] granted_slot;
  logic [bfbp_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, status, granted_slot, capacity, input ready);
  modport sink   (input valid, status, granted_slot, capacity, output ready);
endinterface

FILE: hdl/bfbp_cell.sv
// One cell of the pool chain: entry CELL_IDX of both pools and one token stage.
// Depends on bfbp_pkg for the token and update types.
module bfbp_cell #(
  parameter int POOL_DEPTH = bfbp_pkg::POOL_DEPTH_DEF,
  parameter int CELL_IDX   = 0,
  localparam int IW = $clog2(POOL_DEPTH),
  localparam int CW = $clog2(POOL_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfbp_pkg::tok_t  tok_i,
  input  logic [IW-1:0] tok_idx_i,
  input  logic [CW-1:0] tok_lim_i,
  output bfbp_pkg::tok_t  tok_o,
  output logic [IW-1:0] tok_idx_o,
  output logic [CW-1:0] tok_lim_o,
  input  bfbp_pkg::wcmd_t cmd_i,
  input  logic [IW-1:0] cmd_idx_i,
  output logic [1:0]    busy_o
);
  import bfbp_pkg::*;

  logic [CAP_W-1:0] cap_q [2];
  logic [1:0]       busy_q;
  logic             tok_valid_q;
  tok_t             tok_q, tok_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    lim_q;
  logic             hit;
  logic [CAP_W-1:0] cap_sel;
  logic             take;

  assign hit = (cmd_idx_i == IW'(CELL_IDX));

  // Busy marks of both pools; cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (hit && cmd_i.set_busy) begin
      busy_q[cmd_i.dir] <= 1'b1;
    end else if (hit && cmd_i.clr_busy) begin
      busy_q[cmd_i.dir] <= 1'b0;
    end
  end

  // Capacities are only read below the pool count, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (hit && cmd_i.we_cap) begin
      cap_q[cmd_i.dir] <= cmd_i.cap;
    end
  end

  // This entry takes the token when it is live, inside the pool count, free, fits and beats the best so far.
  assign cap_sel = cap_q[tok_i.dir];
  assign take = tok_i.valid && (CW'(CELL_IDX) < tok_lim_i) && !busy_q[tok_i.dir] &&
                (cap_sel >= {1'b0, tok_i.size}) &&
                (!tok_i.found || (cap_sel < tok_i.best_cap));

  always_comb begin
    tok_d = tok_i;
    idx_d = tok_idx_i;
    if (take) begin
      tok_d.found    = 1'b1;
      tok_d.best_cap = cap_sel;
      idx_d          = IW'(CELL_IDX);
    end
  end

  // Token stage toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    idx_q <= idx_d;
    lim_q <= tok_lim_i;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

  assign tok_idx_o = idx_q;
  assign tok_lim_o = lim_q;
  assign busy_o    = busy_q;

endmodule

FILE: hdl/bfbp_ctrl.sv
// Sequencer of the buffer pool: takes requests, launches the search token,
// grows the size class, updates the cells and holds the result register.
// Depends on bfbp_pkg, the channel interfaces and the assertion macros.
`include "best_fit_buffer_pool_core_assert.svh"

module bfbp_ctrl #(
  parameter int POOL_DEPTH = bfbp_pkg::POOL_DEPTH_DEF,
  localparam int IW = $clog2(POOL_DEPTH),
  localparam int CW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bfbp_in_if.sink                     in_i,
  bfbp_out_if.source                  out_o,
  input  logic [bfbp_pkg::SIZE_W-1:0] base_size_i,
  output bfbp_pkg::tok_t              tok_o,
  output logic [IW-1:0]               tok_idx_o,
  output logic [CW-1:0]               tok_lim_o,
  input  bfbp_pkg::tok_t              tok_i,
  input  logic [IW-1:0]               tok_idx_i,
  output bfbp_pkg::wcmd_t             cmd_o,
  output logic [IW-1:0]               cmd_idx_o,
  input  logic [1:0][POOL_DEPTH-1:0]  busy_i
);
  import bfbp_pkg::*;

  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_DELIVER
  } state_e;

  state_e           state_q;
  logic             dir_q;
  logic [SIZE_W-1:0] size_q;
  logic [CAP_W-1:0] class_q;
  logic [CW-1:0]    cnt_q [2];
  status_e          res_status_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [CAP_W-1:0] res_cap_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [CAP_W-1:0] out_cap_q;

  logic             acc;
  logic [XW-1:0]    slot_x;
  logic             rel_ok;
  logic             class_fits;
  logic [XW-1:0]    best_x;
  logic [XW-1:0]    cnt_x;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;

  // Release check against the pool count and the busy mark.
  assign slot_x = XW'(in_i.slot);
  assign rel_ok = (slot_x < XW'(cnt_q[in_i.direction])) &&
                  busy_i[in_i.direction][slot_x[IW-1:0]];

  assign class_fits = (class_q >= {1'b0, size_q});
  assign best_x     = XW'(tok_idx_i);
  assign cnt_x      = XW'(cnt_q[dir_q]);

  // Token launched into the first cell on an acquire of nonzero size.
  always_comb begin
    tok_o.valid    = acc && (in_i.op == OP_ACQUIRE) && (in_i.request_size != '0);
    tok_o.dir      = in_i.direction;
    tok_o.found    = 1'b0;
    tok_o.size     = in_i.request_size;
    tok_o.best_cap = '0;
    tok_idx_o      = '0;
    tok_lim_o      = cnt_q[in_i.direction];
  end

  // Update broadcast to the cells.
  always_comb begin
    cmd_o     = '0;
    cmd_idx_o = '0;
    case (state_q)
      S_IDLE: begin
        if (acc && (in_i.op == OP_RELEASE) && rel_ok) begin
          cmd_o.clr_busy = 1'b1;
          cmd_o.dir      = in_i.direction;
          cmd_idx_o      = slot_x[IW-1:0];
        end
      end
      S_SCAN: begin
        if (tok_i.valid && tok_i.found) begin
          cmd_o.set_busy = 1'b1;
          cmd_o.dir      = dir_q;
          cmd_idx_o      = tok_idx_i;
        end
      end
      S_GROW: begin
        if (class_fits) begin
          cmd_o.we_cap   = 1'b1;
          cmd_o.set_busy = 1'b1;
          cmd_o.dir      = dir_q;
          cmd_o.cap      = class_q;
          cmd_idx_o      = cnt_x[IW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // State, pool counts, pending result and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dir_q        <= 1'b0;
      size_q       <= '0;
      class_q      <= '0;
      cnt_q[0]     <= '0;
      cnt_q[1]     <= '0;
      res_status_q <= ST_ZERO;
      res_slot_q   <= '0;
      res_cap_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_ZERO;
      out_slot_q   <= '0;
      out_cap_q    <= '0;
    end else begin
      // A result leaving empties the register unless a new one is loaded below.
      if (out_o.valid && out_o.ready && (state_q != S_DELIVER)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            dir_q   <= in_i.direction;
            size_q  <= in_i.request_size;
            class_q <= (base_size_i == '0) ? CAP_W'(1) : {1'b0, base_size_i};
            res_cap_q <= '0;
            if (in_i.op == OP_RELEASE) begin
              res_status_q <= rel_ok ? ST_RELEASED : ST_NOT_BUSY;
              res_slot_q   <= rel_ok ? in_i.slot : '0;
              state_q      <= S_DELIVER;
            end else if (in_i.request_size == '0) begin
              res_status_q <= ST_ZERO;
              res_slot_q   <= '0;
              state_q      <= S_DELIVER;
            end else begin
              res_slot_q <= '0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!class_fits) begin
            class_q <= class_q << 1;
          end
          if (tok_i.valid) begin
            if (tok_i.found) begin
              res_status_q <= ST_REUSED;
              res_slot_q   <= best_x[SLOT_W-1:0];
              res_cap_q    <= tok_i.best_cap;
              state_q      <= S_DELIVER;
            end else if (cnt_q[dir_q] == CW'(POOL_DEPTH)) begin
              res_status_q <= ST_FULL;
              state_q      <= S_DELIVER;
            end else begin
              state_q <= S_GROW;
            end
          end
        end
        S_GROW: begin
          if (class_fits) begin
            cnt_q[dir_q] <= cnt_q[dir_q] + CW'(1);
            res_status_q <= ST_CREATED;
            res_slot_q   <= cnt_x[SLOT_W-1:0];
            res_cap_q    <= class_q;
            state_q      <= S_DELIVER;
          end else begin
            class_q <= class_q << 1;
          end
        end
        S_DELIVER: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            out_cap_q    <= res_cap_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.granted_slot = out_slot_q;
  assign out_o.capacity     = out_cap_q;

  // A pool never grows beyond its depth.
  `BFBP_ASSERT_IMP(a_cnt_bound, 1'b1, (cnt_q[0] <= CW'(POOL_DEPTH)) && (cnt_q[1] <= CW'(POOL_DEPTH)), "pool count beyond depth")
  // A grant only ever goes to a free entry.
  `BFBP_ASSERT_IMP(a_grant_free, cmd_o.set_busy, !busy_i[cmd_o.dir][cmd_idx_o], "grant of a busy entry")
  // A release only ever clears a busy entry.
  `BFBP_ASSERT_IMP(a_release_busy, cmd_o.clr_busy, busy_i[cmd_o.dir][cmd_idx_o], "release of a free entry")
  // An accepted request always leaves the idle state.
  `BFBP_ASSERT_NXT(a_accept_busy, acc, state_q != S_IDLE, "request accepted without work")

endmodule

FILE: hdl/best_fit_buffer_pool_core.sv
// Best-fit buffer pool, two pools of POOL_DEPTH entries held in a chain of cells.
// A release or a zero size is decided on acceptance; a reuse or a full pool once the token has
// walked the chain; a new entry is then made in the grow state, once the size class covers the request.
// Takes one request at a time, ready again once the result is loaded into the output
// register; a stalled result holds the input.
// Reset (rst_ni, async, active low): all entries free, both pools empty, base 65536.
module best_fit_buffer_pool_core #(
  parameter int POOL_DEPTH = bfbp_pkg::POOL_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bfbp_in_if.sink                         in_i,
  bfbp_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfbp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bfbp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bfbp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bfbp_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);

  logic [SIZE_W-1:0]          base_q;
  tok_t                       tok_w [POOL_DEPTH+1];
  logic [IW-1:0]              idx_w [POOL_DEPTH+1];
  logic [CW-1:0]              lim_w [POOL_DEPTH+1];
  wcmd_t                      cmd;
  logic [IW-1:0]              cmd_idx;
  logic [1:0]                 cell_busy [POOL_DEPTH];
  logic [1:0][POOL_DEPTH-1:0] busy_w;
  logic [CW-1:0]              lim_unused;

  // Configuration register, written in the access phase of an APB transfer.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_SIZE_RST;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_BASE_SIZE)) begin
      base_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_BASE_SIZE) ? APB_DATA_W'(base_q) : '0;

  bfbp_ctrl #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .base_size_i(base_q),
    .tok_o      (tok_w[0]),
    .tok_idx_o  (idx_w[0]),
    .tok_lim_o  (lim_w[0]),
    .tok_i      (tok_w[POOL_DEPTH]),
    .tok_idx_i  (idx_w[POOL_DEPTH]),
    .cmd_o      (cmd),
    .cmd_idx_o  (cmd_idx),
    .busy_i     (busy_w)
  );

  // The chain of cells; the token leaves the last cell back to the sequencer.
  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cell
    bfbp_cell #(
      .POOL_DEPTH(POOL_DEPTH),
      .CELL_IDX  (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_w[k]),
      .tok_idx_i(idx_w[k]),
      .tok_lim_i(lim_w[k]),
      .tok_o    (tok_w[k+1]),
      .tok_idx_o(idx_w[k+1]),
      .tok_lim_o(lim_w[k+1]),
      .cmd_i    (cmd),
      .cmd_idx_i(cmd_idx),
      .busy_o   (cell_busy[k])
    );
    assign busy_w[0][k] = cell_busy[k][0];
    assign busy_w[1][k] = cell_busy[k][1];
  end

  // The pool count is not needed past the last cell.
  assign lim_unused = lim_w[POOL_DEPTH];

endmodule

FILE: dv/bfbp_checker.sv
`timescale 1ns / 1ps
// Checker of the best-fit buffer pool: watches the request, result and APB ports,
// predicts every result from its own copy of both pools and counts the mismatches.
// Depends on bfbp_pkg and on the bfbp_in_if and bfbp_out_if channel interfaces.
module bfbp_checker
  import bfbp_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bfbp_in_if                    req_i,
  bfbp_out_if                   rsp_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic                  pready_i,
  output int                    fail_count_o,
  output int                    results_due_o
);

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [CAP_W-1:0]  cap;
  } grant_t;

  // Shadow copy of the pools and of the base size register.
  logic [CAP_W-1:0]  pool_cap  [2][POOL_DEPTH];
  bit                pool_busy [2][POOL_DEPTH];
  int                pool_count[2];
  logic [SIZE_W-1:0] base_q;
  grant_t            grant_q[$];

  // A new entry gets the base size doubled until it covers the request.
  function automatic logic [CAP_W-1:0] round_up_capacity(logic [SIZE_W-1:0] size);
    logic [CAP_W-1:0] c;
    c = (base_q == '0) ? CAP_W'(1) : CAP_W'(base_q);
    while (c < CAP_W'(size)) c = c << 1;
    return c;
  endfunction

  // Works out the result of one request and applies it to the shadow pools.
  function automatic grant_t predict_grant(logic op, logic dir, logic [SIZE_W-1:0] size,
                                           logic [SLOT_W-1:0] slot);
    grant_t g;
    int     fill;
    int     best;
    bit     found;
    g.status = ST_ZERO;
    g.slot   = '0;
    g.cap    = '0;
    fill     = pool_count[dir];
    best     = 0;
    found    = 1'b0;
    if (op == OP_RELEASE) begin
      if (int'(slot) < fill && pool_busy[dir][slot]) begin
        pool_busy[dir][slot] = 1'b0;
        g.status = ST_RELEASED;
        g.slot   = slot;
      end else begin
        g.status = ST_NOT_BUSY;
      end
    end else if (size != '0) begin
      // Smallest fitting free entry; a strict compare keeps the lowest index on ties.
      for (int i = 0; i < fill; i++) begin
        if (!pool_busy[dir][i] && pool_cap[dir][i] >= CAP_W'(size) &&
            (!found || pool_cap[dir][i] < pool_cap[dir][best])) begin
          found = 1'b1;
          best  = i;
        end
      end
      if (found) begin
        pool_busy[dir][best] = 1'b1;
        g.status = ST_REUSED;
        g.slot   = SLOT_W'(best);
        g.cap    = pool_cap[dir][best];
      end else if (fill >= POOL_DEPTH) begin
        g.status = ST_FULL;
      end else begin
        pool_cap[dir][fill]  = round_up_capacity(size);
        pool_busy[dir][fill] = 1'b1;
        pool_count[dir]      = fill + 1;
        g.status = ST_CREATED;
        g.slot   = SLOT_W'(fill);
        g.cap    = pool_cap[dir][fill];
      end
    end
    return g;
  endfunction

  // Register writes, result checks and request predictions, all at the clock edge.
  always @(posedge clk_i) begin
    grant_t want;
    if (!rst_ni) begin
      base_q = BASE_SIZE_RST;
      for (int d = 0; d < 2; d++) begin
        pool_count[d] = 0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
          pool_cap[d][i]  = '0;
          pool_busy[d][i] = 1'b0;
        end
      end
      grant_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_BASE_SIZE) begin
        base_q = pwdata_i[SIZE_W-1:0];
      end

      // A result transfer belongs to an earlier request, so it is checked first.
      if (rsp_i.valid && rsp_i.ready) begin
        if (grant_q.size() == 0) begin
          $error("result with no request pending: status %0d slot %0d capacity %0d",
                 rsp_i.status, rsp_i.granted_slot, rsp_i.capacity);
          fail_count_o++;
        end else begin
          want = grant_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            fail_count_o++;
          end
          if (rsp_i.granted_slot !== want.slot) begin
            $error("granted_slot: expected %0d, got %0d", want.slot, rsp_i.granted_slot);
            fail_count_o++;
          end
          if (rsp_i.capacity !== want.cap) begin
            $error("capacity: expected %0d, got %0d", want.cap, rsp_i.capacity);
            fail_count_o++;
          end
        end
      end

      // Each accepted request queues its predicted result at the tail.
      if (req_i.valid && req_i.ready) begin
        grant_q.insert(grant_q.size(), predict_grant(req_i.op, req_i.direction,
                                                     req_i.request_size, req_i.slot));
      end
    end
    results_due_o = grant_q.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the buffer pool testbench: clock, reset, request and APB stimulus, result
// back-pressure and the verdict. Depends on bfbp_pkg, the channel interfaces,
// bfbp_checker and best_fit_buffer_pool_core.
module tb_top;
  import bfbp_pkg::*;

  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_PHASES      = 6;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_SIZE        = 16777216;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int check_fails;
  int results_due;
  int idle_cycles;
  int cur_base;
  bit tx_idle_en;
  bit rx_idle_en;
  bit rx_hold_req;

  bfbp_in_if  req_if ();
  bfbp_out_if rsp_if ();

  best_fit_buffer_pool_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfbp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .fail_count_o  (check_fails),
    .results_due_o (results_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offers one request and returns at the edge of its transfer.
  task automatic send_item(logic op, logic dir, int size, int slot);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.direction    <= dir;
    req_if.request_size <= size[SIZE_W-1:0];
    req_if.slot         <= slot[SLOT_W-1:0];
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Stops offering and waits until every predicted result has been seen.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (results_due == 0);
    @(posedge clk_i);
  endtask

  // Writes the base size register once the pool is idle.
  task automatic write_base(int value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BASE_SIZE;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    cur_base  = value;
  endtask

  // Random request; sizes cluster around the current size classes and their edges.
  task automatic send_random();
    int eff;
    int top_size;
    int pick;
    int size;
    eff      = (cur_base == 0) ? 1 : cur_base;
    top_size = eff << $urandom_range(0, 4);
    if (top_size > MAX_SIZE) top_size = MAX_SIZE;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      size = 0;
    end else if (pick == 1) begin
      size = MAX_SIZE;
    end else if (pick == 2) begin
      size = $urandom_range(1, MAX_SIZE);
    end else if (pick < 6) begin
      size = (top_size < MAX_SIZE) ? top_size + $urandom_range(0, 1) : top_size;
    end else begin
      size = $urandom_range(1, top_size);
    end
    send_item(($urandom_range(0, 9) < 4) ? OP_RELEASE : OP_ACQUIRE,
              1'($urandom_range(0, 1)), size, $urandom_range(0, 15));
  endtask

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
        rsp_if.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus and verdict.
  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_ACQUIRE;
    req_if.direction    = 1'b0;
    req_if.request_size = '0;
    req_if.slot         = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cur_base            = int'(BASE_SIZE_RST);
    tx_idle_en          = 1'b1;
    rx_idle_en          = 1'b1;
    rx_hold_req         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting at the reset base size.
    send_item(OP_ACQUIRE, 1'b0, 0, 0);          // zero size
    send_item(OP_ACQUIRE, 1'b0, 1, 0);          // smallest size, new entry
    send_item(OP_ACQUIRE, 1'b0, 65536, 15);     // size exactly on the class
    send_item(OP_ACQUIRE, 1'b0, 65537, 0);      // one byte past the class
    send_item(OP_ACQUIRE, 1'b1, MAX_SIZE, 0);   // largest size
    send_item(OP_RELEASE, 1'b0, 0, 0);
    send_item(OP_RELEASE, 1'b0, MAX_SIZE, 0);   // release of a free entry
    send_item(OP_RELEASE, 1'b0, 0, 15);         // slot beyond the pool's count
    send_item(OP_RELEASE, 1'b0, 0, 1);
    send_item(OP_ACQUIRE, 1'b0, 100, 0);        // equal capacities, lowest index wins
    send_item(OP_ACQUIRE, 1'b0, 1048576, 0);
    send_item(OP_RELEASE, 1'b0, 0, 3);
    send_item(OP_ACQUIRE, 1'b0, 30000, 0);      // best fit over a larger free entry
    send_item(OP_RELEASE, 1'b1, 0, 0);
    send_item(OP_ACQUIRE, 1'b1, 5, 0);          // only free entry, far larger
    write_base(1);
    send_item(OP_ACQUIRE, 1'b1, 3, 0);
    send_item(OP_ACQUIRE, 1'b1, MAX_SIZE, 0);   // longest doubling run
    write_base(0);                              // zero base acts as one
    send_item(OP_ACQUIRE, 1'b1, 1, 0);
    send_item(OP_ACQUIRE, 1'b1, 5, 0);
    write_base(MAX_SIZE);
    send_item(OP_ACQUIRE, 1'b0, 1, 0);

    // Random phases, each setting a base size and an idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_base(int'(BASE_SIZE_RST));
          tx_idle_en = 1'b1;
          rx_idle_en = 1'b1;
        end
        1: begin
          write_base(1);
          tx_idle_en  = 1'b0;
          rx_idle_en  = 1'b1;
          rx_hold_req = 1'b1;
        end
        2: begin
          write_base($urandom_range(1, MAX_SIZE));
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
        end
        3: begin
          write_base(MAX_SIZE);
          tx_idle_en = 1'b1;
          rx_idle_en = 1'b0;
        end
        4: begin
          write_base(4096);
          tx_idle_en = 1'b1;
          rx_idle_en = 1'b1;
        end
        default: begin
          write_base(int'(BASE_SIZE_RST));
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 3 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_random();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (check_fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
